/* rtl/core/two_class_priority_queue_assert.svh */
// assertion macros shared by the queue modules
`ifndef TWO_CLASS_PRIORITY_QUEUE_ASSERT_SVH
`define TWO_CLASS_PRIORITY_QUEUE_ASSERT_SVH

// property must hold at every clock edge out of reset
`define TCPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define TCPQ_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* rtl/core/tcpq_pkg.sv */
// shared types and constants for the two-class priority queue
package tcpq_pkg;

    localparam int CLASS_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_W     = 6;
    localparam int IDX_W       = $clog2(CLASS_DEPTH);
    localparam int CNT_W       = $clog2(CLASS_DEPTH + 1);
    localparam int RAM_AW      = IDX_W + 1;
    localparam int RAM_DEPTH   = 1 << RAM_AW;
    localparam int S_TDATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = ((VALUE_WIDTH + COUNT_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = 3;
    localparam logic signed [VALUE_WIDTH-1:0] THRESHOLD_RESET = VALUE_WIDTH'(60);

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic load_ram;
    } dp_cmd_t;

    typedef struct packed {
        logic deq_hit;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/core/two_class_priority_queue.sv */
// Two-class priority queue top level: controller, datapath and class store.
// Enqueue and dequeue-on-empty: result registered in the cycle after the input beat.
// Dequeue with an item: the value passes the registered store read, then the output
// register; no new input is taken during that read.
// Throughput: one command per cycle for enqueues while the output is free.
// Reset (rst_n, async): both classes empty, threshold 60, no result held.
module two_class_priority_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcpq_pkg::VALUE_WIDTH-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tcpq_pkg::S_TDATA_W-1:0] s_tdata,   // value
    input  logic [tcpq_pkg::S_TUSER_W-1:0] s_tuser,   // command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tcpq_pkg::M_TDATA_W-1:0] m_tdata,   // out_value, item_count, zero pad
    output logic [tcpq_pkg::M_TUSER_W-1:0] m_tuser    // out_valid, status
);
    import tcpq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tcpq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .cmd     (cmd),
        .stat    (stat)
    );

    tcpq_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/core/tcpq_ram.sv */
// generic single-write, single-read ram with registered read data
module tcpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/tcpq_datapath.sv */
// ring pointers, class store, threshold register and output register
module tcpq_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcpq_pkg::dp_cmd_t             cmd,
    output tcpq_pkg::dp_stat_t            stat,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcpq_pkg::VALUE_WIDTH-1:0] cfg_data,
    input  logic [tcpq_pkg::S_TDATA_W-1:0] s_tdata,   // value
    input  logic [tcpq_pkg::S_TUSER_W-1:0] s_tuser,   // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tcpq_pkg::M_TDATA_W-1:0] m_tdata,   // out_value, item_count
    output logic [tcpq_pkg::M_TUSER_W-1:0] m_tuser    // out_valid, status
);
    import tcpq_pkg::*;
    `include "two_class_priority_queue_assert.svh"

    logic signed [VALUE_WIDTH-1:0] thr_reg;
    logic [IDX_W-1:0] p_head_reg, p_head_next, p_tail_reg, p_tail_next;
    logic [IDX_W-1:0] n_head_reg, n_head_next, n_tail_reg, n_tail_next;
    logic [CNT_W-1:0] p_count_reg, p_count_next, n_count_reg, n_count_next;
    logic             out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_value_reg, out_value_next;
    logic             out_flag_reg, out_flag_next;
    status_t          out_status_reg, out_status_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    logic                   ram_we, ram_re;
    logic [RAM_AW-1:0]      ram_waddr, ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    logic signed [VALUE_WIDTH-1:0] in_value;
    logic                   in_cmd, is_prio, load_imm;
    status_t                imm_status;
    logic [CNT_W:0]         total_next;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (idx == IDX_W'(CLASS_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = idx + IDX_W'(1);
        end
        return r;
    endfunction

    tcpq_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(RAM_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(in_value),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_value  = s_tdata[VALUE_WIDTH-1:0];
    assign in_cmd    = s_tuser[0];
    assign is_prio   = (in_value >= thr_reg);

    assign stat.deq_hit  = (in_cmd == CMD_DEQ) &&
                           ((p_count_reg != '0) || (n_count_reg != '0));
    assign stat.out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        p_head_next  = p_head_reg;
        p_tail_next  = p_tail_reg;
        p_count_next = p_count_reg;
        n_head_next  = n_head_reg;
        n_tail_next  = n_tail_reg;
        n_count_next = n_count_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = {1'b1, p_tail_reg};
        ram_raddr    = {1'b1, p_head_reg};
        load_imm     = 1'b0;
        imm_status   = STAT_OK;
        if (cmd.accept)
        begin
            if (in_cmd == CMD_ENQ)
            begin
                load_imm = 1'b1;
                if (is_prio)
                begin
                    if (p_count_reg == CNT_W'(CLASS_DEPTH))
                    begin
                        imm_status = STAT_FULL;
                    end
                    else
                    begin
                        ram_we       = 1'b1;
                        ram_waddr    = {1'b1, p_tail_reg};
                        p_tail_next  = ring_next(p_tail_reg);
                        p_count_next = p_count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    if (n_count_reg == CNT_W'(CLASS_DEPTH))
                    begin
                        imm_status = STAT_FULL;
                    end
                    else
                    begin
                        ram_we       = 1'b1;
                        ram_waddr    = {1'b0, n_tail_reg};
                        n_tail_next  = ring_next(n_tail_reg);
                        n_count_next = n_count_reg + CNT_W'(1);
                    end
                end
            end
            else if (p_count_reg != '0)
            begin
                ram_re       = 1'b1;
                ram_raddr    = {1'b1, p_head_reg};
                p_head_next  = ring_next(p_head_reg);
                p_count_next = p_count_reg - CNT_W'(1);
            end
            else if (n_count_reg != '0)
            begin
                ram_re       = 1'b1;
                ram_raddr    = {1'b0, n_head_reg};
                n_head_next  = ring_next(n_head_reg);
                n_count_next = n_count_reg - CNT_W'(1);
            end
            else
            begin
                load_imm   = 1'b1;
                imm_status = STAT_EMPTY;
            end
        end
    end

    assign total_next = {1'b0, p_count_next} + {1'b0, n_count_next};

    always_comb
    begin
        out_value_next  = out_value_reg;
        out_flag_next   = out_flag_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_imm)
        begin
            out_value_next  = '0;
            out_flag_next   = 1'b0;
            out_status_next = imm_status;
            out_count_next  = COUNT_W'(total_next);
            out_valid_next  = 1'b1;
        end
        else if (cmd.load_ram)
        begin
            out_value_next  = ram_rdata;
            out_flag_next   = 1'b1;
            out_status_next = STAT_OK;
            out_count_next  = COUNT_W'(total_next);
            out_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THRESHOLD_RESET;
            p_head_reg    <= '0;
            p_tail_reg    <= '0;
            p_count_reg   <= '0;
            n_head_reg    <= '0;
            n_tail_reg    <= '0;
            n_count_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
            p_head_reg    <= p_head_next;
            p_tail_reg    <= p_tail_next;
            p_count_reg   <= p_count_next;
            n_head_reg    <= n_head_next;
            n_tail_reg    <= n_tail_next;
            n_count_reg   <= n_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_flag_reg   <= out_flag_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        m_tdata = '0;
        m_tdata[VALUE_WIDTH-1:0] = out_value_reg;
        m_tdata[VALUE_WIDTH+COUNT_W-1:VALUE_WIDTH] = out_count_reg;
        m_tuser = {out_status_reg, out_flag_reg};
    end

    `TCPQ_NEVER(a_count_bound, clk, rst_n,
        (p_count_reg > CNT_W'(CLASS_DEPTH)) || (n_count_reg > CNT_W'(CLASS_DEPTH)),
        "class count above depth")
    `TCPQ_NEVER(a_ram_load_free, clk, rst_n, cmd.load_ram && out_valid_reg,
        "store read lands on a held result")
    `TCPQ_ASSERT(a_pop_count, clk, rst_n,
        (cmd.accept && stat.deq_hit) |=>
        (({1'b0, p_count_reg} + {1'b0, n_count_reg}) + (CNT_W + 1)'(1) ==
         $past({1'b0, p_count_reg} + {1'b0, n_count_reg})),
        "dequeue did not remove exactly one item")

endmodule

/* rtl/core/tcpq_ctrl.sv */
// controller: input handshake and store read sequencing
module tcpq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output tcpq_pkg::dp_cmd_t   cmd,
    input  tcpq_pkg::dp_stat_t  stat
);
    import tcpq_pkg::*;
    `include "two_class_priority_queue_assert.svh"

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.load_ram = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready   = stat.out_free;
                cmd.accept = s_tvalid && stat.out_free;
                // a dequeue that finds an item waits in S_READ for the store read
                if (cmd.accept && stat.deq_hit)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.load_ram = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `TCPQ_ASSERT(a_read_follows_pop, clk, rst_n,
        (cmd.accept && stat.deq_hit) |=> cmd.load_ram,
        "store read not taken after dequeue")
    `TCPQ_NEVER(a_no_accept_in_read, clk, rst_n, (state_reg == S_READ) && s_tready,
        "input taken while store read pending")

endmodule

/* sim/tb.sv */
// testbench for the two-class priority queue: predicted results checked beat by beat
module tb;
    import tcpq_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int MAX_SHOWN    = 10;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [COUNT_W-1:0]     count;
        logic                   valid;
        status_t                status;
    } result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [VALUE_WIDTH-1:0] cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    // shadow of the two class rings and the threshold
    logic [VALUE_WIDTH-1:0] prio_mem [CLASS_DEPTH];
    logic [VALUE_WIDTH-1:0] norm_mem [CLASS_DEPTH];
    logic [IDX_W-1:0]       prio_head = '0, prio_tail = '0, norm_head = '0, norm_tail = '0;
    int                     prio_fill = 0, norm_fill = 0;
    logic [VALUE_WIDTH-1:0] threshold = VALUE_WIDTH'(60);

    result_t owed_results [$];
    int      error_count = 0;
    int      cycle_count = 0;
    bit      feed_steady = 1'b0;
    bit      sink_steady = 1'b0;
    int      hold_left = 0;
    logic    ready_level = 1'b1;

    two_class_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // values near the threshold four times in ten, so both classes get traffic
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom();
        else if (r < 8)
            return threshold + VALUE_WIDTH'($urandom_range(0, 8)) - VALUE_WIDTH'(4);
        else if (r == 8)
            return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
    endfunction

    function automatic result_t apply_command(logic cmd, logic [VALUE_WIDTH-1:0] val);
        result_t r;
        r.value  = '0;
        r.valid  = 1'b0;
        r.status = STAT_OK;
        if (cmd == CMD_ENQ)
        begin
            if ($signed(val) >= $signed(threshold))
            begin
                if (prio_fill == CLASS_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    prio_mem[prio_tail] = val;
                    prio_tail = prio_tail + 1'b1;
                    prio_fill++;
                end
            end
            else
            begin
                if (norm_fill == CLASS_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    norm_mem[norm_tail] = val;
                    norm_tail = norm_tail + 1'b1;
                    norm_fill++;
                end
            end
        end
        else if (prio_fill != 0)
        begin
            r.value = prio_mem[prio_head];
            r.valid = 1'b1;
            prio_head = prio_head + 1'b1;
            prio_fill--;
        end
        else if (norm_fill != 0)
        begin
            r.value = norm_mem[norm_head];
            r.valid = 1'b1;
            norm_head = norm_head + 1'b1;
            norm_fill--;
        end
        else
            r.status = STAT_EMPTY;
        r.count = COUNT_W'(prio_fill + norm_fill);
        return r;
    endfunction

    // receiver side: random back-pressure unless held steady
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (sink_steady || $urandom_range(0, 99) < 70)
        begin
            ready_level = 1'b1;
            hold_left <= $urandom_range(0, 8);
        end
        else
        begin
            ready_level = 1'b0;
            hold_left <= pick_gap();
        end
        m_tready <= ready_level;
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.value  = m_tdata[VALUE_WIDTH-1:0];
            got.count  = m_tdata[VALUE_WIDTH+COUNT_W-1:VALUE_WIDTH];
            got.valid  = m_tuser[0];
            got.status = status_t'(m_tuser[2:1]);
            if (owed_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_SHOWN)
                    $display("tb: result beat with nothing pending: value %h count %0d",
                             got.value, got.count);
            end
            else
            begin
                want = owed_results.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                        $display("tb: mismatch value %h/%h count %0d/%0d valid %b/%b status %0d/%0d",
                                 want.value, got.value, want.count, got.count,
                                 want.valid, got.valid, want.status, got.status);
                end
            end
        end
    end

    task automatic send_cmd(input logic cmd, input logic [VALUE_WIDTH-1:0] val);
        int gap;
        gap = 0;
        if (!feed_steady && $urandom_range(0, 99) < 40)
            gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= val;
        do @(posedge clk); while (!s_tready);
        owed_results.push_back(apply_command(cmd, val));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_threshold(input logic [VALUE_WIDTH-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        threshold = val;
    endtask

    // reset threshold of 60; a priority item slips ahead of two normal items, which keep their order
    task automatic test_empty_and_order();
        send_cmd(CMD_DEQ, 32'hdead_beef);
        send_cmd(CMD_ENQ, 32'd5);
        send_cmd(CMD_ENQ, 32'd60);
        send_cmd(CMD_ENQ, 32'd59);
        send_cmd(CMD_DEQ, 32'h0);
        send_cmd(CMD_DEQ, 32'hffff_ffff);
        send_cmd(CMD_DEQ, 32'h0);
        send_cmd(CMD_DEQ, 32'h0);
    endtask

    task automatic test_threshold_extremes();
        set_threshold(32'h7fff_ffff);
        send_cmd(CMD_ENQ, 32'h7fff_fffe);
        send_cmd(CMD_ENQ, 32'h7fff_ffff);
        send_cmd(CMD_DEQ, 32'h0);
        send_cmd(CMD_DEQ, 32'h0);
    endtask

    // with the lowest threshold every value is priority, so the class fills
    task automatic test_class_full();
        set_threshold(32'h8000_0000);
        send_cmd(CMD_ENQ, 32'h8000_0000);
        send_cmd(CMD_ENQ, 32'hffff_ffff);
        for (int i = 0; i < CLASS_DEPTH - 2; i++)
            send_cmd(CMD_ENQ, $urandom());
        send_cmd(CMD_ENQ, 32'h7fff_ffff);
        send_cmd(CMD_DEQ, $urandom());
    endtask

    task automatic run_phase(input logic [VALUE_WIDTH-1:0] thr, input int items,
                             input int enq_pct, input bit steady);
        set_threshold(thr);
        feed_steady = steady;
        sink_steady = steady;
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(0, 99) < enq_pct)
                send_cmd(CMD_ENQ, pick_value());
            else
                send_cmd(CMD_DEQ, $urandom());
        end
        feed_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    task automatic test_random_mix();
        run_phase(32'd60, 100, 70, 1'b0);
        run_phase($urandom(), 100, 40, 1'b0);
        run_phase(32'h0, 90, 85, 1'b1);
        run_phase(32'h8000_0000, 90, 55, 1'b0);
        run_phase(32'h7fff_ffff, 90, 80, 1'b0);
        run_phase($urandom(), 80, 30, 1'b0);
        run_phase($urandom(), 80, 60, 1'b1);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_and_order();
        test_threshold_extremes();
        test_class_full();
        test_random_mix();
        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0 && owed_results.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
